// ===== hdl/lzl_pkg.sv =====
// Package for the LZ4 legacy stream decoder: sizes, result codes and beat types.
// No dependencies; used by the top level and the parser of the decoder.
package lzl_pkg;

   localparam int HIST_DEPTH = 65536;             // power of two, 1024 to 65536
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int LEN_BITS   = 32;                // 16 to 32

   localparam logic [31:0] MAGIC_WORD = 32'h184C2103;
   localparam logic [31:0] CONST_WORD = 32'h4D000000;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_BYTE     = 3'd1,
      KIND_BADMAGIC = 3'd2,
      KIND_BADCONST = 3'd3,
      KIND_BADOFF   = 3'd4,
      KIND_REFUSED  = 3'd5
   } kind_type;

   localparam logic OP_FEED  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic       copy_pending;
      logic       block_end;
   } rsp_type;

   // Control handed from the parser to the output and history stage.
   typedef struct packed {
      kind_type             kind;
      logic                 copy_pending;
      logic                 block_end;
      logic                 hist_wr;
      logic                 from_mem;
      logic [7:0]           lit_byte;
      logic [HIST_AW-1:0]   rd_addr;
      logic [HIST_AW-1:0]   wr_addr;
   } step_type;

endpackage

// ===== hdl/lz4_legacy_stream_decoder_top.sv =====
// Top level of the LZ4 legacy stream decoder: parser, history RAM and output stage.
// Depends on lzl_pkg, lzl_ram and lzl_parser.
// A request beat yields its response beat from the output stage register in the cycle after acceptance.
// Throughput: one beat per cycle while rsp_ready is high, feeds and drains alike, set by one history RAM access.
// Reset (synchronous, active high) clears parser state and the output stage; the
// history RAM is not cleared, as only written entries can ever be read.
module lz4_legacy_stream_decoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lzl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lzl_pkg::rsp_type rsp_data
);
   import lzl_pkg::*;

   // The output stage holds one step. Its history write happens when its beat
   // leaves, so a new beat can be taken only in cycles when the stage is empty or empties.
   logic     take;
   step_type step;
   step_type s2_ff;
   logic     s2_valid_ff;
   logic     hit_ff, hit_in;
   logic [7:0] fwd_ff;
   logic [7:0] rd_data;
   logic [7:0] s2_byte;
   logic     leave;

   assign req_ready = !s2_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign leave     = s2_valid_ff && rsp_ready;

   lzl_parser u_parser (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .step  (step)
   );

   // A copy read that hits the entry written in the same cycle takes the byte
   // from the forwarding register instead of the RAM's stale data.
   assign s2_byte = !s2_ff.from_mem ? s2_ff.lit_byte : (hit_ff ? fwd_ff : rd_data);
   assign hit_in  = s2_valid_ff && s2_ff.hist_wr && (step.rd_addr == s2_ff.wr_addr);

   lzl_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_history (
      .clock   (clock),
      .wr_en   (leave && s2_ff.hist_wr),
      .wr_addr (s2_ff.wr_addr),
      .wr_data (s2_byte),
      .rd_en   (take && step.from_mem),
      .rd_addr (step.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (take) begin
         s2_valid_ff <= 1'b1;
      end else if (leave) begin
         s2_valid_ff <= 1'b0;
      end
      if (take) begin
         s2_ff  <= step;
         hit_ff <= hit_in;
         fwd_ff <= s2_byte;
      end
   end

   assign rsp_valid             = s2_valid_ff;
   assign rsp_data.kind         = s2_ff.kind;
   assign rsp_data.out_byte     = (s2_ff.kind == KIND_BYTE) ? s2_byte : 8'd0;
   assign rsp_data.copy_pending = s2_ff.copy_pending;
   assign rsp_data.block_end    = s2_ff.block_end;

endmodule

// ===== hdl/lzl_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module lzl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/lzl_parser.sv =====
// Stream parser of the LZ4 legacy decoder: header, block lengths, tokens and copies.
// Depends on lzl_pkg; issues history reads and writes as a step_type record.
module lzl_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  lzl_pkg::req_type req,
   output lzl_pkg::step_type step
);
   import lzl_pkg::*;

   typedef enum logic [3:0] {
      PH_MAGIC, PH_ULEN, PH_CONST, PH_BLKLEN, PH_TOKEN, PH_LITEXT,
      PH_LIT, PH_OFFLO, PH_OFFHI, PH_MEXT, PH_COPY
   } phase_type;

   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   phase_type           phase_ff, phase_in;
   logic [1:0]          bidx_ff, bidx_in;
   logic [31:0]         hword_ff, hword_in;
   logic [31:0]         bsize_ff, bsize_in;
   logic [LEN_BITS-1:0] bseen_ff, bseen_in;
   logic [3:0]          mnib_ff, mnib_in;
   logic [LEN_BITS-1:0] litrem_ff, litrem_in;
   logic [15:0]         dist_ff, dist_in;
   logic [LEN_BITS-1:0] cprem_ff, cprem_in;
   logic [HIST_AW-1:0]  wp_ff, wp_in;
   logic [HIST_AW:0]    fill_ff, fill_in;
   logic                err_ff, err_in;

   function automatic logic [LEN_BITS-1:0] sat_add(logic [LEN_BITS-1:0] a,
                                                   logic [LEN_BITS-1:0] b);
      logic [LEN_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
   endfunction

   logic [7:0]  b;
   logic [15:0] dist_full;
   logic [31:0] hword_tmp;
   logic [31:0] bsize_tmp;

   always_comb begin
      phase_in  = phase_ff;
      bidx_in   = bidx_ff;
      hword_in  = hword_ff;
      bsize_in  = bsize_ff;
      bseen_in  = bseen_ff;
      mnib_in   = mnib_ff;
      litrem_in = litrem_ff;
      dist_in   = dist_ff;
      cprem_in  = cprem_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      err_in    = err_ff;
      step          = '0;
      step.kind     = KIND_NONE;
      step.wr_addr  = wp_ff;
      step.rd_addr  = wp_ff - dist_ff[HIST_AW-1:0];
      b         = req.in_byte;
      dist_full = {b, dist_ff[7:0]};
      hword_tmp = (bidx_ff == 2'd0) ? 32'd0 : hword_ff;
      hword_tmp[8*bidx_ff +: 8] = b;
      bsize_tmp = (bidx_ff == 2'd0) ? 32'd0 : bsize_ff;
      bsize_tmp[8*bidx_ff +: 8] = b;

      if (err_ff) begin
         step.kind = KIND_REFUSED;
      end else if (req.opcode == OP_DRAIN) begin
         if (phase_ff != PH_COPY || cprem_ff == '0) begin
            step.kind = KIND_REFUSED;
         end else begin
            step.kind     = KIND_BYTE;
            step.hist_wr  = 1'b1;
            step.from_mem = 1'b1;
            wp_in    = wp_ff + 1'b1;
            fill_in  = (fill_ff[HIST_AW]) ? fill_ff : fill_ff + 1'b1;
            cprem_in = cprem_ff - 1'b1;
            if (cprem_ff == {{(LEN_BITS-1){1'b0}}, 1'b1}) begin
               phase_in = PH_TOKEN;
            end
         end
      end else if (phase_ff == PH_COPY) begin
         step.kind = KIND_REFUSED;
      end else if (phase_ff == PH_MAGIC || phase_ff == PH_ULEN || phase_ff == PH_CONST) begin
         hword_in = hword_tmp;
         bidx_in  = bidx_ff + 2'd1;
         if (bidx_ff == 2'd3) begin
            if (phase_ff == PH_MAGIC && hword_tmp != MAGIC_WORD) begin
               step.kind = KIND_BADMAGIC;
               err_in    = 1'b1;
            end else if (phase_ff == PH_CONST && hword_tmp != CONST_WORD) begin
               step.kind = KIND_BADCONST;
               err_in    = 1'b1;
            end else if (phase_ff == PH_MAGIC) begin
               phase_in = PH_ULEN;
            end else if (phase_ff == PH_ULEN) begin
               phase_in = PH_CONST;
            end else begin
               phase_in = PH_BLKLEN;
            end
         end
      end else if (phase_ff == PH_BLKLEN) begin
         bsize_in = bsize_tmp;
         bidx_in  = bidx_ff + 2'd1;
         if (bidx_ff == 2'd3) begin
            bseen_in = '0;
            phase_in = PH_TOKEN;
         end
      end else begin
         bseen_in = sat_add(bseen_ff, {{(LEN_BITS-1){1'b0}}, 1'b1});
         // Body bytes; when the literals end, close the block or expect an offset.
         unique case (phase_ff)
            PH_TOKEN: begin
               mnib_in   = b[3:0];
               litrem_in = {{(LEN_BITS-4){1'b0}}, b[7:4]};
               if (b[7:4] == 4'd15) begin
                  phase_in = PH_LITEXT;
               end else if (b[7:4] != 4'd0) begin
                  phase_in = PH_LIT;
               end else if (32'(bseen_in) == bsize_ff) begin
                  step.block_end = 1'b1;
                  phase_in = PH_BLKLEN;
                  bidx_in  = 2'd0;
                  bsize_in = '0;
               end else begin
                  phase_in = PH_OFFLO;
                  dist_in  = '0;
               end
            end
            PH_LITEXT: begin
               litrem_in = sat_add(litrem_ff, {{(LEN_BITS-8){1'b0}}, b});
               if (b != 8'd255) begin
                  phase_in = PH_LIT;
               end
            end
            PH_LIT: begin
               step.kind     = KIND_BYTE;
               step.hist_wr  = 1'b1;
               step.lit_byte = b;
               wp_in   = wp_ff + 1'b1;
               fill_in = (fill_ff[HIST_AW]) ? fill_ff : fill_ff + 1'b1;
               if (litrem_ff != '0) begin
                  litrem_in = litrem_ff - 1'b1;
               end
               if (litrem_in == '0) begin
                  if (32'(bseen_in) == bsize_ff) begin
                     step.block_end = 1'b1;
                     phase_in = PH_BLKLEN;
                     bidx_in  = 2'd0;
                     bsize_in = '0;
                  end else begin
                     phase_in = PH_OFFLO;
                     dist_in  = '0;
                  end
               end
            end
            PH_OFFLO: begin
               dist_in  = {8'd0, b};
               phase_in = PH_OFFHI;
            end
            PH_OFFHI: begin
               dist_in = dist_full;
               if (dist_full == 16'd0 || 17'(dist_full) > 17'(fill_ff)) begin
                  step.kind = KIND_BADOFF;
                  err_in    = 1'b1;
                  cprem_in  = '0;
               end else if (mnib_ff == 4'd15) begin
                  cprem_in = LEN_BITS'(15);
                  phase_in = PH_MEXT;
               end else begin
                  cprem_in = sat_add({{(LEN_BITS-4){1'b0}}, mnib_ff}, LEN_BITS'(4));
                  phase_in = PH_COPY;
               end
            end
            PH_MEXT: begin
               cprem_in = sat_add(cprem_ff, {{(LEN_BITS-8){1'b0}}, b});
               if (b != 8'd255) begin
                  cprem_in = sat_add(cprem_in, LEN_BITS'(4));
                  phase_in = PH_COPY;
               end
            end
            default: begin
               phase_in = PH_TOKEN;
            end
         endcase
      end
      step.copy_pending = !err_in && phase_in == PH_COPY && cprem_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         bidx_ff   <= '0;
         hword_ff  <= '0;
         bsize_ff  <= '0;
         bseen_ff  <= '0;
         mnib_ff   <= '0;
         litrem_ff <= '0;
         dist_ff   <= '0;
         cprem_ff  <= '0;
         wp_ff     <= '0;
         fill_ff   <= '0;
         err_ff    <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         bidx_ff   <= bidx_in;
         hword_ff  <= hword_in;
         bsize_ff  <= bsize_in;
         bseen_ff  <= bseen_in;
         mnib_ff   <= mnib_in;
         litrem_ff <= litrem_in;
         dist_ff   <= dist_in;
         cprem_ff  <= cprem_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         err_ff    <= err_in;
      end
   end

endmodule
